@@ rtl/tso_pkg.sv @@
package tso_pkg;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_INIT  = 9'b000000010,
        ST_SQ    = 9'b000000100,
        ST_CP    = 9'b000001000,
        ST_DAMP  = 9'b000010000,
        ST_REC   = 9'b000100000,
        ST_HORNP = 9'b001000000,
        ST_HORNV = 9'b010000000,
        ST_OUT   = 9'b100000000
    } t_state;

    typedef enum logic [1:0] {
        REG_DAMPING   = 2'd0,
        REG_STEP_SIZE = 2'd1,
        REG_GO_BACK   = 2'd2,
        REG_NUM_TERMS = 2'd3
    } t_reg_idx;

    localparam logic REQ_LOAD = 1'b0;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v,
                                                 output logic clip);
        clip = 1'b0;
        if (v > 66'sd2147483647) begin
            clip = 1'b1;
            return 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            clip = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

@@ rtl/tso_if.sv @@
interface tso_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] init_pos;
    logic [31:0] init_vel;
    modport source (output valid, req_type, init_pos, init_vel, input ready);
    modport sink (input valid, req_type, init_pos, init_vel, output ready);
endinterface

interface tso_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pos_out;
    logic [31:0] vel_out;
    logic        saturated;
    modport source (output valid, pos_out, vel_out, saturated, input ready);
    modport sink (input valid, pos_out, vel_out, saturated, output ready);
endinterface

interface tso_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/taylor_series_oscillator_stepper.sv @@
// Van der Pol Taylor stepper. A load word passes through one state to the
// output register; a step word runs its series products on one shared 32x32
// multiply-accumulate unit, one product per cycle, for n terms (3 up to
// MAX_TERMS, 16 at reset). The block accepts no word while a step is at work
// or an untaken result is held; the result sits in an output register. Q format, saturating arithmetic.
module taylor_series_oscillator_stepper
    import tso_pkg::*;
#(
    parameter int MAX_TERMS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tso_in_if.sink     in_ch,
    tso_out_if.source  out_ch,
    tso_cfg_if.sink    cfg_ch
);
    localparam int IW = $clog2(MAX_TERMS);
    localparam int CW = $clog2(MAX_TERMS + 1);

    logic signed [31:0] r_damping;
    logic [30:0]        r_step;
    logic               r_back;
    logic [5:0]         r_nterms;

    logic signed [31:0] r_pos, r_vel;
    logic signed [31:0] r_x [MAX_TERMS];
    logic signed [31:0] r_d [MAX_TERMS];
    logic signed [31:0] r_s [MAX_TERMS];

    t_state             r_state;
    logic [CW-1:0]      r_n, r_k, r_i, r_nn;
    logic signed [31:0] r_acc;
    logic               r_clip;
    logic               r_ovalid;
    logic signed [31:0] r_opos, r_ovel;
    logic               r_osat;

    // entry k: round(2^32 / ((k+2)(k+1)))
    logic [31:0] recip_tab [MAX_TERMS];
    for (genvar g = 0; g < MAX_TERMS; g++) begin : g_recip
        localparam longint Den = longint'(g + 2) * longint'(g + 1);
        localparam logic [31:0] Rcp = 32'(((64'sd1 <<< 32) + (Den >>> 1)) / Den);
        assign recip_tab[g] = Rcp;
    end

    assign cfg_ch.ready  = 1'b1;
    assign in_ch.ready   = (r_state == ST_IDLE) && !r_ovalid;
    assign out_ch.valid  = r_ovalid;
    assign out_ch.pos_out = r_opos;
    assign out_ch.vel_out = r_ovel;
    assign out_ch.saturated = r_osat;

    logic signed [31:0] h;
    assign h = r_back ? -$signed({1'b0, r_step}) : $signed({1'b0, r_step});

    // effective term count
    logic [CW-1:0] nn_eff;
    always_comb begin
        if (r_nterms < 6'd3) nn_eff = CW'(3);
        else if (32'(r_nterms) > MAX_TERMS) nn_eff = CW'(MAX_TERMS);
        else nn_eff = CW'(r_nterms);
    end

    // shared multiplier operand select
    logic signed [31:0] ma, mb;
    logic [IW-1:0]      ia, ib;
    assign ia = r_i[IW-1:0];
    assign ib = IW'(r_n - r_i);
    always_comb begin
        ma = r_acc;
        mb = h;
        case (r_state)
            ST_SQ:    begin ma = r_x[ia]; mb = r_x[ib]; end
            ST_CP:    begin ma = r_s[ia]; mb = r_d[ib]; end
            ST_DAMP:  begin ma = r_damping; mb = r_acc; end
            default:  begin ma = r_acc; mb = h; end
        endcase
    end

    logic signed [63:0] prod;
    logic signed [65:0] qround;
    assign prod = ma * mb;
    assign qround = (66'(prod) + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

    logic signed [31:0] qm;
    logic               qm_c;
    always_comb qm = sat32(qround, qm_c);

    // reciprocal path for x[k+2]
    logic signed [31:0] sd, rq;
    logic               sd_c0, sd_c1, rq_c;
    logic signed [31:0] tneg;
    logic signed [65:0] rprod;
    always_comb begin
        tneg  = sat32(-66'(r_acc), sd_c0);
        sd    = sat32(66'(tneg) - 66'(r_x[r_k[IW-1:0]]), sd_c1);
        rprod = (66'(sd) * $signed({34'd0, recip_tab[r_k[IW-1:0]]}) + (66'sd1 <<< 31)) >>> 32;
        rq    = sat32(rprod, rq_c);
    end

    // accumulate, derivative and square fixups
    logic signed [31:0] acc_add, sq_fix, dv, hacc;
    logic               aa_c, sf_c, dv_c, ha_c;
    logic [IW-1:0]      hidx;
    assign hidx = IW'(r_i - CW'(1));
    always_comb begin
        acc_add = sat32(66'(r_acc) + 66'(qm), aa_c);
        sq_fix  = sat32(66'(acc_add) - (66'sd1 <<< FRAC_BITS), sf_c);
        dv      = sat32(66'($signed({1'b0, r_n})) * 66'(r_x[r_n[IW-1:0]]), dv_c);
        hacc    = sat32(66'(qm) + 66'(r_state == ST_HORNP ? r_x[hidx] : r_d[hidx]),
                        ha_c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_damping <= 32'sd65536;
            r_step    <= 31'd6554;
            r_back    <= 1'b0;
            r_nterms  <= 6'd16;
            r_pos     <= '0;
            r_vel     <= '0;
            r_state   <= ST_IDLE;
            r_ovalid  <= 1'b0;
        end else begin
            if (cfg_ch.valid) begin
                case (t_reg_idx'(cfg_ch.index))
                    REG_DAMPING:   r_damping <= cfg_ch.data;
                    REG_STEP_SIZE: r_step    <= cfg_ch.data[30:0];
                    REG_GO_BACK:   r_back    <= cfg_ch.data[0];
                    REG_NUM_TERMS: r_nterms  <= cfg_ch.data[5:0];
                    default: ;
                endcase
            end
            if (r_ovalid && out_ch.ready) r_ovalid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (in_ch.valid && in_ch.ready) begin
                        if (in_ch.req_type == REQ_LOAD) begin
                            r_pos <= in_ch.init_pos;
                            r_vel <= in_ch.init_vel;
                            r_clip <= 1'b0;
                            r_state <= ST_OUT;
                        end else begin
                            r_nn <= nn_eff;
                            r_clip <= 1'b0;
                            r_state <= ST_INIT;
                        end
                    end
                end
                ST_INIT: begin
                    r_x[0] <= r_pos;
                    r_x[1] <= r_vel;
                    r_n <= '0;
                    r_i <= '0;
                    r_acc <= '0;
                    r_state <= ST_SQ;
                end
                ST_SQ: begin
                    // square coefficient n; derivative n-1 on first pass
                    if (r_i == '0 && r_n != '0) begin
                        r_d[IW'(r_n - CW'(1))] <= dv;
                    end
                    r_clip <= r_clip | qm_c | aa_c | (r_i == '0 && r_n != '0 && dv_c)
                              | (r_i == r_n && r_n == '0 && sf_c);
                    if (r_i == r_n) begin
                        if (r_n == '0) begin
                            r_s[0] <= sq_fix;
                        end else begin
                            r_s[r_n[IW-1:0]] <= acc_add;
                        end
                        r_acc <= '0;
                        if (r_n == '0) begin
                            r_i <= '0;
                            r_n <= CW'(1);
                        end else if (r_n == r_nn - CW'(1)) begin
                            r_i <= r_nn;
                            r_state <= ST_HORNP;
                        end else begin
                            r_i <= '0;
                            r_k <= r_n - CW'(1);
                            r_n <= r_n - CW'(1);
                            r_state <= ST_CP;
                        end
                    end else begin
                        r_acc <= acc_add;
                        r_i <= r_i + CW'(1);
                    end
                end
                ST_CP: begin
                    r_clip <= r_clip | qm_c | aa_c;
                    if (r_i == r_n) begin
                        r_acc <= acc_add;
                        r_state <= ST_DAMP;
                    end else begin
                        r_acc <= acc_add;
                        r_i <= r_i + CW'(1);
                    end
                end
                ST_DAMP: begin
                    r_clip <= r_clip | qm_c;
                    r_acc <= qm;
                    r_state <= ST_REC;
                end
                ST_REC: begin
                    r_clip <= r_clip | sd_c0 | sd_c1 | rq_c;
                    r_x[IW'(r_k + CW'(2))] <= rq;
                    r_n <= r_k + CW'(2);
                    r_i <= '0;
                    r_acc <= '0;
                    r_state <= ST_SQ;
                end
                ST_HORNP: begin
                    r_clip <= r_clip | qm_c | ha_c;
                    if (r_i == CW'(1)) begin
                        r_opos <= hacc;
                        r_acc <= '0;
                        r_i <= r_nn - CW'(1);
                        r_state <= ST_HORNV;
                    end else begin
                        r_acc <= hacc;
                        r_i <= r_i - CW'(1);
                    end
                end
                ST_HORNV: begin
                    r_clip <= r_clip | qm_c | ha_c;
                    if (r_i == CW'(1)) begin
                        r_pos <= r_opos;
                        r_vel <= hacc;
                        r_state <= ST_OUT;
                    end else begin
                        r_acc <= hacc;
                        r_i <= r_i - CW'(1);
                    end
                end
                ST_OUT: begin
                    r_opos <= r_pos;
                    r_ovel <= r_vel;
                    r_osat <= r_clip;
                    r_ovalid <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !in_ch.ready) else $error("accept while busy");
    a_out_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |=> r_ovalid) else $error("result lost");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQ) |-> (r_i <= r_n)) else $error("index overrun");
`endif

endmodule

@@ test/tso_checker.sv @@
module tso_checker
    import tso_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    tso_in_if      in_ch,
    tso_out_if     out_ch,
    tso_cfg_if     cfg_ch,
    output int     o_fail_count,
    output int     o_pending,
    output int     o_loads,
    output int     o_steps,
    output int     o_clipped
);

    localparam int Terms = 32;

    typedef struct packed {
        logic [31:0] pos;
        logic [31:0] vel;
        logic        sat;
    } t_osc_word;

    logic signed [31:0] damp_q;
    logic [30:0]        step_q;
    logic               backward;
    logic [5:0]         terms_q;

    int osc_pos;
    int osc_vel;
    int xs [Terms];
    int dxs [Terms];
    int sqm [Terms];
    bit clipped;

    t_osc_word state_q[$];
    int issued;
    int retired;

    assign o_pending = issued - retired;

    function automatic int clamp(input longint v);
        if (v > longint'(32'sh7fffffff)) begin
            clipped = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -longint'(64'sd2147483648)) begin
            clipped = 1'b1;
            return 32'sh80000000;
        end
        return int'(v);
    endfunction

    function automatic int qprod(input int a, input int b);
        return clamp((longint'(a) * longint'(b) + 64'sd32768) >>> 16);
    endfunction

    function automatic int qsum(input int a, input int b);
        return clamp(longint'(a) + longint'(b));
    endfunction

    function automatic int qdiff(input int a, input int b);
        return clamp(longint'(a) - longint'(b));
    endfunction

    function automatic longint inv_pair(input int k);
        longint d;
        d = longint'(k + 2) * longint'(k + 1);
        return ((64'sd1 <<< 32) + d / 2) / d;
    endfunction

    function automatic int div_pair(input int v, input int k);
        return clamp((longint'(v) * inv_pair(k) + (64'sd1 <<< 31)) >>> 32);
    endfunction

    function automatic int conv(input int p[Terms], input int q[Terms], input int n);
        int acc;
        acc = 0;
        for (int i = 0; i <= n; i++)
            acc = qsum(acc, qprod(p[i], q[n - i]));
        return acc;
    endfunction

    function automatic void extend(input int n);
        if (n > 0)
            dxs[n - 1] = clamp(longint'(n) * longint'(xs[n]));
        sqm[n] = conv(xs, xs, n);
        if (n == 0)
            sqm[0] = qdiff(sqm[0], 32'sd65536);
    endfunction

    function automatic int eval_poly(input int c[Terms], input int len, input int h);
        int acc;
        acc = 0;
        for (int i = len - 1; i >= 0; i--)
            acc = qsum(qprod(acc, h), c[i]);
        return acc;
    endfunction

    function automatic void advance();
        int n;
        int t;
        int sd;
        int h;
        int np;
        int nv;
        n = int'(terms_q);
        if (n < 3) n = 3;
        if (n > Terms) n = Terms;
        xs[0] = osc_pos;
        xs[1] = osc_vel;
        extend(0);
        extend(1);
        for (int k = 0; k < n - 2; k++) begin
            t = qprod(damp_q, conv(sqm, dxs, k));
            sd = qdiff(qdiff(0, t), xs[k]);
            xs[k + 2] = div_pair(sd, k);
            extend(k + 2);
        end
        h = int'({1'b0, step_q});
        if (backward)
            h = -h;
        np = eval_poly(xs, n, h);
        nv = eval_poly(dxs, n - 1, h);
        osc_pos = np;
        osc_vel = nv;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h expected %h (word %0d)", what, got, want, retired);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_osc_word w;
        t_osc_word e;
        if (!i_rst_n) begin
            damp_q   <= 32'sd65536;
            step_q   <= 31'd6554;
            backward <= 1'b0;
            terms_q  <= 6'd16;
            osc_pos  = 0;
            osc_vel  = 0;
            state_q.delete();
            issued   <= 0;
            retired  <= 0;
            o_fail_count = 0;
            o_loads   <= 0;
            o_steps   <= 0;
            o_clipped <= 0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (t_reg_idx'(cfg_ch.index))
                    REG_DAMPING:   damp_q   <= cfg_ch.data;
                    REG_STEP_SIZE: step_q   <= cfg_ch.data[30:0];
                    REG_GO_BACK:   backward <= cfg_ch.data[0];
                    REG_NUM_TERMS: terms_q  <= cfg_ch.data[5:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                clipped = 1'b0;
                if (in_ch.req_type == REQ_LOAD) begin
                    osc_pos = in_ch.init_pos;
                    osc_vel = in_ch.init_vel;
                    o_loads <= o_loads + 1;
                end else begin
                    advance();
                    o_steps <= o_steps + 1;
                    if (clipped) o_clipped <= o_clipped + 1;
                end
                w.pos = osc_pos;
                w.vel = osc_vel;
                w.sat = clipped;
                state_q = {state_q, w};
                issued <= issued + 1;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (state_q.size() == 0) begin
                    report("unexpected word", out_ch.pos_out, 32'h0);
                end else begin
                    e = state_q.pop_front();
                    if (out_ch.pos_out !== e.pos) report("pos_out", out_ch.pos_out, e.pos);
                    if (out_ch.vel_out !== e.vel) report("vel_out", out_ch.vel_out, e.vel);
                    if (out_ch.saturated !== e.sat)
                        report("saturated", 32'(out_ch.saturated), 32'(e.sat));
                    retired <= retired + 1;
                end
            end
        end
    end

endmodule

@@ test/tb.sv @@
module tb;
    import tso_pkg::*;

    localparam int StallLimit = 50000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   idle_mode = 0;
    int   fails;
    int   pending;
    int   loads;
    int   steps;
    int   clipped;
    int   quiet_cycles = 0;
    int   words_sent = 0;

    tso_in_if  in_ch ();
    tso_out_if out_ch ();
    tso_cfg_if cfg_ch ();

    taylor_series_oscillator_stepper dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .cfg_ch  (cfg_ch)
    );

    tso_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_ch       (cfg_ch),
        .o_fail_count (fails),
        .o_pending    (pending),
        .o_loads      (loads),
        .o_steps      (steps),
        .o_clipped    (clipped)
    );

    always #5 i_clk = ~i_clk;

    // receiver stalls
    always @(posedge i_clk) begin
        case (idle_mode)
            0:       out_ch.ready <= ($urandom_range(0, 99) >= 48);
            1:       out_ch.ready <= ($urandom_range(0, 99) >= 30);
            default: out_ch.ready <= 1'b1;
        endcase
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("timeout with %0d words outstanding", pending);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic bit sender_idle();
        case (idle_mode)
            0:       return $urandom_range(0, 99) < 30;
            1:       return $urandom_range(0, 99) < 48;
            default: return 1'b0;
        endcase
    endfunction

    task automatic send_word(input logic kind, input logic [31:0] pos, input logic [31:0] vel);
        while (sender_idle()) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.req_type <= kind;
        in_ch.init_pos <= pos;
        in_ch.init_vel <= vel;
        do @(posedge i_clk); while (!in_ch.ready);
        words_sent++;
        if (words_sent < 300) idle_mode = 0;
        else if (words_sent < 600) idle_mode = 1;
        else idle_mode = 2;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        cfg_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic setup(input logic [31:0] damp, input logic [31:0] h, input logic back,
                         input logic [31:0] n);
        drain();
        write_reg(REG_DAMPING, damp);
        write_reg(REG_STEP_SIZE, h);
        write_reg(REG_GO_BACK, {31'd0, back});
        write_reg(REG_NUM_TERMS, n);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [31:0] moderate();
        return 32'($urandom_range(0, 8 * 65536)) - 32'd262144;
    endfunction

    initial begin
        logic [31:0] damp;
        logic [31:0] h;
        logic [31:0] n;
        int burst;
        in_ch.valid    <= 1'b0;
        in_ch.req_type <= REQ_LOAD;
        in_ch.init_pos <= '0;
        in_ch.init_vel <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= REG_DAMPING;
        cfg_ch.data    <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings
        send_word(~REQ_LOAD, '0, '0);
        send_word(REQ_LOAD, 32'h7fffffff, 32'h80000000);
        send_word(REQ_LOAD, 32'h80000000, 32'h7fffffff);
        send_word(REQ_LOAD, 32'h00010000, 32'h00000000);
        send_word(~REQ_LOAD, '0, '0);
        send_word(~REQ_LOAD, '0, '0);
        send_word(REQ_LOAD, 32'h7fffffff, 32'h7fffffff);
        send_word(~REQ_LOAD, '0, '0);
        // short series, backward, max step
        setup(32'h80000000, 32'h7fffffff, 1'b1, 32'd0);
        send_word(REQ_LOAD, 32'h00020000, 32'hffff0000);
        send_word(~REQ_LOAD, '0, '0);
        setup(32'h7fffffff, 32'd0, 1'b0, 32'd2);
        send_word(~REQ_LOAD, '0, '0);
        setup(32'h00008000, 32'd6554, 1'b1, 32'd63);
        send_word(REQ_LOAD, 32'h00018000, 32'h00004000);
        send_word(~REQ_LOAD, '0, '0);
        setup(32'h00000000, 32'd65536, 1'b0, 32'd32);
        send_word(~REQ_LOAD, '0, '0);
        setup(32'hfffe0000, 32'd3277, 1'b0, 32'd33);
        send_word(REQ_LOAD, 32'h80000000, 32'h80000000);
        send_word(~REQ_LOAD, '0, '0);
        setup(32'h00010000, 32'd6554, 1'b0, 32'd3);
        send_word(REQ_LOAD, 32'h00020000, 32'h00000000);
        send_word(~REQ_LOAD, '0, '0);
        send_word(~REQ_LOAD, '0, '0);

        // random bursts: a load followed by steps, with some noise
        while (words_sent < 850) begin
            damp = ($urandom_range(0, 7) == 0) ? $urandom
                 : 32'($urandom_range(0, 393216)) - 32'd196608;
            h = ($urandom_range(0, 7) == 0) ? 32'($urandom >> 1)
              : 32'($urandom_range(0, 32768));
            n = ($urandom_range(0, 9) == 0) ? 32'($urandom_range(0, 63))
              : 32'($urandom_range(3, 12));
            setup(damp, h, 1'($urandom_range(0, 1)), n);
            send_word(REQ_LOAD, moderate(), moderate());
            burst = $urandom_range(8, 30);
            for (int i = 0; i < burst; i++) begin
                if ($urandom_range(0, 9) == 0)
                    send_word(REQ_LOAD, $urandom, $urandom);
                else
                    send_word(~REQ_LOAD, $urandom, $urandom);
            end
        end

        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (50) @(posedge i_clk);
        $display("run covered %0d loads and %0d steps, %0d steps clipped", loads, steps,
                 clipped);
        $display("settings included extreme damping, step size, direction and term counts");
        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/tso_pkg.sv
rtl/tso_if.sv
rtl/taylor_series_oscillator_stepper.sv
test/tso_checker.sv
test/tb.sv
